FILE: sv/dhkt_pkg.sv
package dhkt_pkg;

	// the remainder unit folds modulo 2^IDX_W - 1, so the slot count stays of that form
	localparam int TABLE_SLOTS   = 8191;
	localparam int MAX_KEY_CHARS = 4;
	localparam int KEY_CAP       = (MAX_KEY_CHARS < 4) ? MAX_KEY_CHARS : 4;

	localparam int HASH_W     = 32;
	localparam int LEN_W      = 3;
	localparam int SLOT_OUT_W = 13;
	localparam int IDX_W      = $clog2(TABLE_SLOTS);
	localparam int FOLD_STEPS = 3;
	localparam int CNT_W      = $clog2(FOLD_STEPS);

	localparam int H1_SEED = 0;
	localparam int H2_SEED = 5381;
	localparam int H1_MULT = 33;
	localparam int H2_MULT = 31;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	typedef struct packed {
		logic              kind;
		logic [HASH_W-1:0] key_chars;
		logic [LEN_W-1:0]  key_len;
	} req_t;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot_index;
		logic                  found;
		logic                  table_full;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [LEN_W-1:0]  len;
		logic [HASH_W-1:0] chars;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

FILE: sv/dhkt_slot_ram.sv
module dhkt_slot_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [dhkt_pkg::IDX_W-1:0]    waddr,
	input  dhkt_pkg::slot_entry_t         wdata,
	input  logic                          re,
	input  logic [dhkt_pkg::IDX_W-1:0]    raddr,
	output dhkt_pkg::slot_entry_t         rdata
);

	dhkt_pkg::slot_entry_t mem_q [dhkt_pkg::TABLE_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/dhkt_rem_unit.sv
// Remainders by end-around folding, two lanes in lockstep:
// r1 = a mod TABLE_SLOTS, r2 = b mod (TABLE_SLOTS-1).
// TABLE_SLOTS is 2^IDX_W - 1, so a fold adds the bits above IDX_W onto the low
// bits. TABLE_SLOTS-1 = 2 * (2^(IDX_W-1) - 1): b is halved, folded, and its lsb
// put back. FOLD_STEPS folds leave at most one modulus; a compare and subtract
// finishes. done pulses as the last fold is registered.
module dhkt_rem_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dhkt_pkg::HASH_W-1:0]    a,
	input  logic [dhkt_pkg::HASH_W-1:0]    b,
	output logic                           done,
	output logic [dhkt_pkg::IDX_W-1:0]     r1,
	output logic [dhkt_pkg::IDX_W-1:0]     r2
);

	localparam int IW = dhkt_pkg::IDX_W;
	localparam int HW = dhkt_pkg::HASH_W;
	localparam logic [HW-1:0] M1 = HW'(dhkt_pkg::TABLE_SLOTS);
	localparam logic [HW-1:0] M2 = HW'((dhkt_pkg::TABLE_SLOTS - 1) / 2);

	logic [HW-1:0]               x1_q, x2_q;
	logic                        lsb_q;
	logic [dhkt_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q, done_q;
	logic [IW-2:0]               q2;

	always_comb begin
		r1 = (x1_q >= M1) ? IW'(x1_q - M1) : IW'(x1_q);
		q2 = (x2_q >= M2) ? (IW-1)'(x2_q - M2) : (IW-1)'(x2_q);
		r2 = {q2, lsb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dhkt_pkg::CNT_W'(dhkt_pkg::FOLD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x1_q  <= a;
			x2_q  <= b >> 1;
			lsb_q <= b[0];
		end else if (busy_q) begin
			x1_q <= HW'(x1_q[IW-1:0]) + (x1_q >> IW);
			x2_q <= HW'(x2_q[IW-2:0]) + (x2_q >> (IW-1));
		end
	end

	assign done = done_q;

endmodule

FILE: sv/double_hash_key_table_core.sv
// channel  dir  handshake            word
// req      in   req_valid/req_ready  kind, key_chars, key_len
// rsp      out  rsp_valid/rsp_ready  slot_index, found, table_full
//
// Per word, accept to accept with rsp free: an idle step, the hash steps,
// one per key byte and one more, the remainder folds, then a RAM read and a
// check per probe, and a finish step.
// After reset a clearing pass writes every slot empty, with req_ready low.
// One word at a time; rsp is registered, so a stalled rsp holds only the
// finish step, and req is taken again once the result is loaded.
module double_hash_key_table_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dhkt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dhkt_pkg::rsp_t rsp
);

	localparam int IW = dhkt_pkg::IDX_W;
	localparam int LW = dhkt_pkg::LEN_W;
	localparam int HW = dhkt_pkg::HASH_W;

	dhkt_pkg::state_t state_q, state_nxt;

	logic              kind_q;
	logic [LW-1:0]     len_q;
	logic [HW-1:0]     key_q;
	logic [LW-1:0]     i_q;
	logic [HW-1:0]     h1_q, h2_q;
	logic [IW-1:0]     home_q, idx_q, step_q, clr_q;
	logic              rsp_valid_q;
	dhkt_pkg::rsp_t    rsp_q, res_q;

	logic [LW-1:0]     in_len;
	logic [HW-1:0]     in_mask;
	logic [LW-1:0]     sh;
	logic [7:0]        cur_byte;
	logic              hash_last;

	logic              rem_start, rem_done;
	logic [IW-1:0]     rem_r1, rem_r2;

	logic              ram_we, ram_re;
	logic [IW-1:0]     ram_waddr;
	dhkt_pkg::slot_entry_t ram_wdata, ram_rdata;

	logic              slot_free, key_match, stop_here, wrap;
	logic [IW:0]       probe_sum;
	logic [IW-1:0]     idx_nxt;
	logic              accept, rsp_load;

	dhkt_slot_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	dhkt_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.a      (h1_q),
		.b      (h2_q),
		.done   (rem_done),
		.r1     (rem_r1),
		.r2     (rem_r2)
	);

	always_comb begin
		in_len = (req.key_len > LW'(dhkt_pkg::KEY_CAP)) ? LW'(dhkt_pkg::KEY_CAP) : req.key_len;
		// shift by 32 gives zero, so a 4-byte key keeps all bits
		in_mask = (HW'(1) << {in_len, 3'b000}) - HW'(1);
		sh = len_q - i_q - LW'(1);
		cur_byte = 8'(key_q >> {sh, 3'b000});
		hash_last = (i_q == len_q);

		slot_free = !ram_rdata.valid;
		key_match = ram_rdata.valid && (ram_rdata.len == len_q) && (ram_rdata.chars == key_q);
		stop_here = (kind_q == dhkt_pkg::KIND_INSERT) ? slot_free : (slot_free || key_match);
		probe_sum = {1'b0, idx_q} + {1'b0, step_q};
		idx_nxt = (probe_sum >= (IW+1)'(dhkt_pkg::TABLE_SLOTS)) ?
			IW'(probe_sum - (IW+1)'(dhkt_pkg::TABLE_SLOTS)) : probe_sum[IW-1:0];
		wrap = (idx_nxt == home_q);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dhkt_pkg::ST_CLEAR: begin
				if (clr_q == IW'(dhkt_pkg::TABLE_SLOTS - 1)) state_nxt = dhkt_pkg::ST_IDLE;
			end
			dhkt_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = dhkt_pkg::ST_HASH;
			end
			dhkt_pkg::ST_HASH: begin
				if (hash_last) state_nxt = dhkt_pkg::ST_MOD;
			end
			dhkt_pkg::ST_MOD: begin
				if (rem_done) state_nxt = dhkt_pkg::ST_READ;
			end
			dhkt_pkg::ST_READ: begin
				state_nxt = dhkt_pkg::ST_CHECK;
			end
			dhkt_pkg::ST_CHECK: begin
				state_nxt = (stop_here || wrap) ? dhkt_pkg::ST_FINISH : dhkt_pkg::ST_READ;
			end
			dhkt_pkg::ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) state_nxt = dhkt_pkg::ST_IDLE;
			end
			default: state_nxt = dhkt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = 1'b0;
		rem_start = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '{valid: 1'b1, len: len_q, chars: key_q};
		rsp_load  = 1'b0;
		case (state_q)
			dhkt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			dhkt_pkg::ST_IDLE:  req_ready = 1'b1;
			dhkt_pkg::ST_HASH:  rem_start = hash_last;
			dhkt_pkg::ST_READ:  ram_re = 1'b1;
			dhkt_pkg::ST_CHECK: begin
				ram_we = (kind_q == dhkt_pkg::KIND_INSERT) && slot_free;
			end
			dhkt_pkg::ST_FINISH: rsp_load = !rsp_valid_q || rsp_ready;
			default: ;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dhkt_pkg::ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == dhkt_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			len_q  <= in_len;
			key_q  <= req.key_chars & in_mask;
			i_q    <= '0;
			h1_q   <= HW'(dhkt_pkg::H1_SEED);
			h2_q   <= HW'(dhkt_pkg::H2_SEED);
		end
		if (state_q == dhkt_pkg::ST_HASH && !hash_last) begin
			h1_q <= h1_q * HW'(dhkt_pkg::H1_MULT) + HW'(cur_byte);
			h2_q <= h2_q * HW'(dhkt_pkg::H2_MULT) + HW'(cur_byte);
			i_q  <= i_q + 1'b1;
		end
		if (state_q == dhkt_pkg::ST_MOD && rem_done) begin
			home_q <= rem_r1;
			idx_q  <= rem_r1;
			step_q <= rem_r2 + 1'b1;
		end
		if (state_q == dhkt_pkg::ST_CHECK) begin
			if (stop_here) begin
				// a lookup that stops on an empty slot reports slot 0
				res_q.slot_index <= ((kind_q == dhkt_pkg::KIND_INSERT) || key_match) ?
					dhkt_pkg::SLOT_OUT_W'(idx_q) : '0;
				res_q.found      <= (kind_q == dhkt_pkg::KIND_INSERT) || key_match;
				res_q.table_full <= 1'b0;
			end else if (wrap) begin
				res_q.slot_index <= '0;
				res_q.found      <= 1'b0;
				res_q.table_full <= (kind_q == dhkt_pkg::KIND_INSERT);
			end else begin
				idx_q <= idx_nxt;
			end
		end
		if (rsp_load) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("req taken while a word is in flight");

	a_rem_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> state_q == dhkt_pkg::ST_MOD)
		else $error("remainder finished outside hash reduction");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dhkt_pkg::ST_READ |-> (idx_q < IW'(dhkt_pkg::TABLE_SLOTS)) && (step_q != '0))
		else $error("probe index or step out of range");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == dhkt_pkg::ST_FINISH)
		else $error("result raised outside finish step");

endmodule
